FILE: hw/rtl/ctlt_pkg.sv
// ============================================================================
// ctlt_pkg: shared types and character tables for the C-like tokenizer
// Lexer modes, token kind and error codes, and the character class and
// operator lookup functions used by the tokenizer datapath.
// ============================================================================
`timescale 1ns / 1ps

package ctlt_pkg;

	// Default widths of the position counters.
	localparam int DEF_OFFSET_BITS = 24;
	localparam int DEF_LINE_BITS   = 20;
	localparam int DEF_COLUMN_BITS = 16;

	typedef enum logic [3:0] {
		M_IDLE   = 4'd0,
		M_HOLD   = 4'd1,
		M_LCOM   = 4'd2,
		M_BCOM   = 4'd3,
		M_BSTAR  = 4'd4,
		M_IDENT  = 4'd5,
		M_ZERO   = 4'd6,
		M_DEC    = 4'd7,
		M_HEX0   = 4'd8,
		M_HEX    = 4'd9,
		M_FLOAT  = 4'd10,
		M_CHOPEN = 4'd11,
		M_CHESC  = 4'd12,
		M_CHBODY = 4'd13,
		M_STR    = 4'd14,
		M_STRESC = 4'd15
	} mode_t;

	localparam logic [5:0] K_IDENT    = 6'd0;
	localparam logic [5:0] K_INT      = 6'd1;
	localparam logic [5:0] K_FLOAT    = 6'd2;
	localparam logic [5:0] K_CHAR     = 6'd3;
	localparam logic [5:0] K_STRING   = 6'd4;
	localparam logic [5:0] K_ELLIPSIS = 6'd5;
	localparam logic [5:0] K_TWO      = 6'd6;
	localparam logic [5:0] K_ONE      = 6'd19;
	localparam logic [5:0] K_END      = 6'd43;
	localparam logic [5:0] K_INVALID  = 6'd44;

	localparam logic [2:0] E_NONE      = 3'd0;
	localparam logic [2:0] E_UNRECOG   = 3'd1;
	localparam logic [2:0] E_HEX_EMPTY = 3'd2;
	localparam logic [2:0] E_CHAR_OPEN = 3'd3;
	localparam logic [2:0] E_CHAR_NONE = 3'd4;
	localparam logic [2:0] E_CHAR_LONG = 3'd5;
	localparam logic [2:0] E_STR_OPEN  = 3'd6;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LOWX   = 8'h78;

	// Position of the dot and the slash in the one-character operator list.
	localparam logic [4:0] ONE_DOT   = 5'd10;
	localparam logic [4:0] ONE_SLASH = 5'd15;

	typedef struct packed {
		logic       hit;
		logic [4:0] idx;
	} op_hit_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
	endfunction

	function automatic logic id_start(input logic [7:0] c);
		return is_alpha(c) || (c == CH_UNDER);
	endfunction

	function automatic logic id_cont(input logic [7:0] c);
		return id_start(c) || is_digit(c);
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
	endfunction

	// One-character operators in the order ( ) { } [ ] < > : , . ; + - * / = ! ~ & | ? % ^
	function automatic op_hit_t one_index(input logic [7:0] c);
		op_hit_t r;
		r.hit = 1'b1;
		case (c)
			8'h28: r.idx = 5'd0;
			8'h29: r.idx = 5'd1;
			8'h7B: r.idx = 5'd2;
			8'h7D: r.idx = 5'd3;
			8'h5B: r.idx = 5'd4;
			8'h5D: r.idx = 5'd5;
			8'h3C: r.idx = 5'd6;
			8'h3E: r.idx = 5'd7;
			8'h3A: r.idx = 5'd8;
			8'h2C: r.idx = 5'd9;
			8'h2E: r.idx = 5'd10;
			8'h3B: r.idx = 5'd11;
			8'h2B: r.idx = 5'd12;
			8'h2D: r.idx = 5'd13;
			8'h2A: r.idx = 5'd14;
			8'h2F: r.idx = 5'd15;
			8'h3D: r.idx = 5'd16;
			8'h21: r.idx = 5'd17;
			8'h7E: r.idx = 5'd18;
			8'h26: r.idx = 5'd19;
			8'h7C: r.idx = 5'd20;
			8'h3F: r.idx = 5'd21;
			8'h25: r.idx = 5'd22;
			8'h5E: r.idx = 5'd23;
			default: begin
				r.hit = 1'b0;
				r.idx = 5'd0;
			end
		endcase
		return r;
	endfunction

	// Two-character operators: -> && || == != <= >= ++ -- << >> += -=
	function automatic op_hit_t two_index(input logic [7:0] a, input logic [7:0] b);
		op_hit_t r;
		r.hit = 1'b1;
		case ({a, b})
			16'h2D3E: r.idx = 5'd0;
			16'h2626: r.idx = 5'd1;
			16'h7C7C: r.idx = 5'd2;
			16'h3D3D: r.idx = 5'd3;
			16'h213D: r.idx = 5'd4;
			16'h3C3D: r.idx = 5'd5;
			16'h3E3D: r.idx = 5'd6;
			16'h2B2B: r.idx = 5'd7;
			16'h2D2D: r.idx = 5'd8;
			16'h3C3C: r.idx = 5'd9;
			16'h3E3E: r.idx = 5'd10;
			16'h2B3D: r.idx = 5'd11;
			16'h2D3D: r.idx = 5'd12;
			default: begin
				r.hit = 1'b0;
				r.idx = 5'd0;
			end
		endcase
		return r;
	endfunction

	function automatic logic two_first(input logic [7:0] c);
		logic r;
		case (c)
			8'h2D, 8'h26, 8'h7C, 8'h3D, 8'h21, 8'h3C, 8'h3E, 8'h2B: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/ctlt_outq.sv
// ============================================================================
// ctlt_outq: token output buffer
// Holds the up to three tokens that one source byte produces and hands them
// out one beat at a time, flagging the last token of each batch.
// ============================================================================
`timescale 1ns / 1ps

module ctlt_outq #(
	parameter int DATA_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [1:0]           push_cnt,
	input  logic [DATA_BITS-1:0] push_data [3],
	output logic                 room,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DATA_BITS-1:0] out_data,
	output logic                 out_last
);

	logic [DATA_BITS-1:0] ent_q [3];
	logic [1:0]           cnt_q;
	logic [1:0]           head_q;

	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = ent_q[head_q];
	assign out_last  = (cnt_q == 2'd1);
	// A new batch may land while the final token of the current one leaves.
	assign room      = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			head_q <= 2'd0;
		end else if (push) begin
			cnt_q  <= push_cnt;
			head_q <= 2'd0;
		end else if (out_valid && out_ready) begin
			cnt_q  <= cnt_q - 2'd1;
			head_q <= head_q + 2'd1;
		end
	end

`ifndef ASSERT_OFF
	a_head_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, head_q} + {1'b0, cnt_q}) <= 3'd3)
		else $error("token buffer read pointer runs past the batch");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room)
		else $error("batch pushed while tokens still wait");

	a_pop_counts_down: assert property (@(posedge clk) disable iff (!arst_n)
		(!push && out_valid && out_ready) |=> (cnt_q == $past(cnt_q) - 2'd1))
		else $error("token count did not drop after a beat");
`endif

endmodule

FILE: hw/rtl/c_like_source_tokenizer.sv
// ============================================================================
// c_like_source_tokenizer: byte-serial C-style lexer
// Takes one source byte per beat (or an end marker) and returns tokens with
// kind, byte offsets, start and end line/column, and an error code. Blanks and
// both comment styles are skipped; an unclosed block comment runs to the end.
// A byte is taken every cycle while the token buffer has room: the lexer
// state and the position counters are updated in a single pass between the
// input and the token buffer. A byte can complete up to three tokens (two
// pending dots plus a one-character operator); those leave the token buffer
// one per cycle while out_ready is high, and input is held off while more
// than the last of them still waits. After an invalid token nothing is
// emitted until the end marker, which then returns the block to its reset
// state. Offsets, lines and columns saturate at their maximum. Identifiers
// are never classified as keywords.
// ============================================================================
`timescale 1ns / 1ps

module c_like_source_tokenizer #(
	parameter int OFFSET_BITS = ctlt_pkg::DEF_OFFSET_BITS,
	parameter int LINE_BITS   = ctlt_pkg::DEF_LINE_BITS,
	parameter int COLUMN_BITS = ctlt_pkg::DEF_COLUMN_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             source_byte,
	input  logic                   end_marker,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [5:0]             token_kind,
	output logic [OFFSET_BITS-1:0] start_offset,
	output logic [OFFSET_BITS-1:0] end_offset,
	output logic [LINE_BITS-1:0]   start_line,
	output logic [COLUMN_BITS-1:0] start_column,
	output logic [LINE_BITS-1:0]   end_line,
	output logic [COLUMN_BITS-1:0] end_column,
	output logic [2:0]             error_code,
	output logic                   last_of_run
);
	import ctlt_pkg::*;

	typedef struct packed {
		logic [5:0]             kind;
		logic [2:0]             err;
		logic [OFFSET_BITS-1:0] so;
		logic [LINE_BITS-1:0]   sl;
		logic [COLUMN_BITS-1:0] sc;
		logic [OFFSET_BITS-1:0] eo;
		logic [LINE_BITS-1:0]   el;
		logic [COLUMN_BITS-1:0] ec;
	} tok_t;

	localparam int TokBits = $bits(tok_t);

	localparam logic [OFFSET_BITS-1:0] OffMax = '1;
	localparam logic [LINE_BITS-1:0]   LinMax = '1;
	localparam logic [COLUMN_BITS-1:0] ColMax = '1;
	localparam logic [LINE_BITS-1:0]   LineOne = LINE_BITS'(1);
	localparam logic [COLUMN_BITS-1:0] ColOne  = COLUMN_BITS'(1);

	function automatic tok_t mk_tok(
		input logic [5:0] kind, input logic [2:0] err,
		input logic [OFFSET_BITS-1:0] so, input logic [LINE_BITS-1:0] sl,
		input logic [COLUMN_BITS-1:0] sc,
		input logic [OFFSET_BITS-1:0] eo, input logic [LINE_BITS-1:0] el,
		input logic [COLUMN_BITS-1:0] ec);
		tok_t t;
		t.kind = kind;
		t.err  = err;
		t.so   = so;
		t.sl   = sl;
		t.sc   = sc;
		t.eo   = eo;
		t.el   = el;
		t.ec   = ec;
		return t;
	endfunction

	// Lexer state and cursor.
	mode_t                  mode_q, mode_d;
	logic [7:0]             pend_q, pend_d;
	logic                   dot2_q, dot2_d;
	logic [OFFSET_BITS-1:0] off_q, off_d;
	logic [LINE_BITS-1:0]   line_q, line_d;
	logic [COLUMN_BITS-1:0] col_q, col_d;
	logic [OFFSET_BITS-1:0] tso_q, tso_d;
	logic [LINE_BITS-1:0]   tsl_q, tsl_d;
	logic [COLUMN_BITS-1:0] tsc_q, tsc_d;
	logic                   halt_q, halt_d;

	logic                   accept;
	logic                   cv;
	logic [OFFSET_BITS-1:0] adv_off;
	logic [LINE_BITS-1:0]   adv_line;
	logic [COLUMN_BITS-1:0] adv_col;
	logic [OFFSET_BITS-1:0] dot_off;
	logic [COLUMN_BITS-1:0] dot_col;
	op_hit_t                one_c, one_p, two_pc;

	// Up to two tokens come out of the pending token, one more from the
	// byte itself once the lexer falls back to idle.
	tok_t                   tok_a0, tok_a1, tok_b;
	logic                   ea0, ea1, eb;
	logic                   fall, consume;
	logic [1:0]             push_cnt;
	logic [TokBits-1:0]     push_data [3];
	tok_t                   head_tok;
	logic [TokBits-1:0]     head_bits;

	assign accept = in_valid && in_ready;
	assign cv     = !end_marker;

	assign adv_off  = (off_q == OffMax) ? off_q : off_q + 1'b1;
	assign adv_line = (source_byte == CH_LF)
		? ((line_q == LinMax) ? line_q : line_q + 1'b1) : line_q;
	assign adv_col  = (source_byte == CH_LF) ? ColOne
		: ((col_q == ColMax) ? col_q : col_q + 1'b1);
	// Second of two held dots starts one byte after the first.
	assign dot_off  = (tso_q == OffMax) ? tso_q : tso_q + 1'b1;
	assign dot_col  = (tsc_q == ColMax) ? tsc_q : tsc_q + 1'b1;

	assign one_c  = one_index(source_byte);
	assign one_p  = one_index(pend_q);
	assign two_pc = two_index(pend_q, source_byte);

	always_comb begin
		mode_d  = mode_q;
		pend_d  = pend_q;
		dot2_d  = dot2_q;
		tso_d   = tso_q;
		tsl_d   = tsl_q;
		tsc_d   = tsc_q;
		halt_d  = halt_q;
		ea0     = 1'b0;
		ea1     = 1'b0;
		eb      = 1'b0;
		fall    = 1'b0;
		consume = 1'b0;
		tok_a0  = mk_tok(K_INVALID, E_UNRECOG, tso_q, tsl_q, tsc_q, off_q, line_q, col_q);
		tok_a1  = mk_tok(K_ONE + {1'b0, ONE_DOT}, E_NONE, dot_off, tsl_q, dot_col,
			off_q, line_q, col_q);
		tok_b   = mk_tok(K_END, E_NONE, off_q, line_q, col_q, off_q, line_q, col_q);

		if (!halt_q) begin
			unique case (mode_q)
				M_IDLE: begin
					fall = 1'b1;
				end
				M_HOLD: begin
					if (pend_q == CH_SLASH) begin
						if (cv && (source_byte == CH_SLASH)) begin
							consume = 1'b1;
							mode_d  = M_LCOM;
						end else if (cv && (source_byte == CH_STAR)) begin
							consume = 1'b1;
							mode_d  = M_BCOM;
						end else begin
							ea0          = 1'b1;
							tok_a0.kind  = K_ONE + {1'b0, ONE_SLASH};
							tok_a0.err   = E_NONE;
							fall         = 1'b1;
						end
					end else if (pend_q == CH_DOT) begin
						if (cv && (source_byte == CH_DOT)) begin
							consume = 1'b1;
							if (dot2_q) begin
								ea0       = 1'b1;
								tok_a0    = mk_tok(K_ELLIPSIS, E_NONE, tso_q, tsl_q, tsc_q,
									adv_off, adv_line, adv_col);
								mode_d    = M_IDLE;
							end else begin
								dot2_d    = 1'b1;
							end
						end else begin
							ea0 = 1'b1;
							if (dot2_q) begin
								// Two lone dots: the first ends where the second starts.
								tok_a0 = mk_tok(K_ONE + {1'b0, ONE_DOT}, E_NONE,
									tso_q, tsl_q, tsc_q, dot_off, tsl_q, dot_col);
								ea1    = 1'b1;
							end else begin
								tok_a0.kind = K_ONE + {1'b0, ONE_DOT};
								tok_a0.err  = E_NONE;
							end
							fall = 1'b1;
						end
					end else if (cv && two_pc.hit) begin
						consume = 1'b1;
						ea0     = 1'b1;
						tok_a0  = mk_tok(K_TWO + {1'b0, two_pc.idx}, E_NONE, tso_q, tsl_q,
							tsc_q, adv_off, adv_line, adv_col);
						mode_d  = M_IDLE;
					end else begin
						ea0  = 1'b1;
						fall = 1'b1;
						if (one_p.hit) begin
							tok_a0.kind = K_ONE + {1'b0, one_p.idx};
							tok_a0.err  = E_NONE;
						end
					end
				end
				M_LCOM: begin
					if (!cv || (source_byte == CH_LF)) begin
						fall = 1'b1;
					end else begin
						consume = 1'b1;
					end
				end
				M_BCOM, M_BSTAR: begin
					if (!cv) begin
						fall = 1'b1;
					end else begin
						consume = 1'b1;
						if ((mode_q == M_BSTAR) && (source_byte == CH_SLASH)) begin
							mode_d = M_IDLE;
						end else if (source_byte == CH_STAR) begin
							mode_d = M_BSTAR;
						end else begin
							mode_d = M_BCOM;
						end
					end
				end
				M_IDENT: begin
					if (cv && id_cont(source_byte)) begin
						consume = 1'b1;
					end else begin
						ea0         = 1'b1;
						tok_a0.kind = K_IDENT;
						tok_a0.err  = E_NONE;
						fall        = 1'b1;
					end
				end
				M_ZERO, M_DEC: begin
					if (cv && (mode_q == M_ZERO) && (source_byte == CH_LOWX)) begin
						consume = 1'b1;
						mode_d  = M_HEX0;
					end else if (cv && is_digit(source_byte)) begin
						consume = 1'b1;
						mode_d  = M_DEC;
					end else if (cv && (source_byte == CH_DOT)) begin
						consume = 1'b1;
						mode_d  = M_FLOAT;
					end else begin
						ea0         = 1'b1;
						tok_a0.kind = K_INT;
						tok_a0.err  = E_NONE;
						fall        = 1'b1;
					end
				end
				M_HEX0: begin
					if (cv && is_hex(source_byte)) begin
						consume = 1'b1;
						mode_d  = M_HEX;
					end else begin
						ea0        = 1'b1;
						tok_a0.err = E_HEX_EMPTY;
						halt_d     = 1'b1;
					end
				end
				M_HEX: begin
					if (cv && is_hex(source_byte)) begin
						consume = 1'b1;
					end else begin
						ea0         = 1'b1;
						tok_a0.kind = K_INT;
						tok_a0.err  = E_NONE;
						fall        = 1'b1;
					end
				end
				M_FLOAT: begin
					if (cv && is_digit(source_byte)) begin
						consume = 1'b1;
					end else begin
						ea0         = 1'b1;
						tok_a0.kind = K_FLOAT;
						tok_a0.err  = E_NONE;
						fall        = 1'b1;
					end
				end
				M_CHOPEN: begin
					if (!cv) begin
						ea0        = 1'b1;
						tok_a0.err = E_CHAR_OPEN;
						halt_d     = 1'b1;
					end else if (source_byte == CH_BSLASH) begin
						consume = 1'b1;
						mode_d  = M_CHESC;
					end else if (source_byte == CH_QUOTE) begin
						ea0        = 1'b1;
						tok_a0.err = E_CHAR_NONE;
						halt_d     = 1'b1;
					end else begin
						consume = 1'b1;
						mode_d  = M_CHBODY;
					end
				end
				M_CHESC: begin
					if (!cv) begin
						ea0        = 1'b1;
						tok_a0.err = E_CHAR_OPEN;
						halt_d     = 1'b1;
					end else begin
						consume = 1'b1;
						mode_d  = M_CHBODY;
					end
				end
				M_CHBODY: begin
					if (cv && (source_byte == CH_QUOTE)) begin
						consume = 1'b1;
						ea0     = 1'b1;
						tok_a0  = mk_tok(K_CHAR, E_NONE, tso_q, tsl_q, tsc_q,
							adv_off, adv_line, adv_col);
						mode_d  = M_IDLE;
					end else begin
						ea0        = 1'b1;
						tok_a0.err = E_CHAR_LONG;
						halt_d     = 1'b1;
					end
				end
				M_STR: begin
					if (!cv) begin
						ea0        = 1'b1;
						tok_a0.err = E_STR_OPEN;
						halt_d     = 1'b1;
					end else begin
						consume = 1'b1;
						if (source_byte == CH_DQUOTE) begin
							ea0    = 1'b1;
							tok_a0 = mk_tok(K_STRING, E_NONE, tso_q, tsl_q, tsc_q,
								adv_off, adv_line, adv_col);
							mode_d = M_IDLE;
						end else if (source_byte == CH_BSLASH) begin
							mode_d = M_STRESC;
						end
					end
				end
				M_STRESC: begin
					if (!cv) begin
						ea0        = 1'b1;
						tok_a0.err = E_STR_OPEN;
						halt_d     = 1'b1;
					end else begin
						consume = 1'b1;
						mode_d  = M_STR;
					end
				end
				default: begin
					fall = 1'b1;
				end
			endcase

			// Back to idle with the same byte offered again.
			if (fall) begin
				mode_d = M_IDLE;
				dot2_d = 1'b0;
				if (!cv) begin
					eb = 1'b1;
				end else if (!is_blank(source_byte)) begin
					tso_d = off_q;
					tsl_d = line_q;
					tsc_d = col_q;
					if ((source_byte == CH_SLASH) || (source_byte == CH_DOT)
						|| two_first(source_byte)) begin
						consume = 1'b1;
						pend_d  = source_byte;
						mode_d  = M_HOLD;
					end else if (id_start(source_byte)) begin
						consume = 1'b1;
						mode_d  = M_IDENT;
					end else if (is_digit(source_byte)) begin
						consume = 1'b1;
						mode_d  = (source_byte == CH_ZERO) ? M_ZERO : M_DEC;
					end else if (source_byte == CH_QUOTE) begin
						consume = 1'b1;
						mode_d  = M_CHOPEN;
					end else if (source_byte == CH_DQUOTE) begin
						consume = 1'b1;
						mode_d  = M_STR;
					end else if (one_c.hit) begin
						consume = 1'b1;
						eb      = 1'b1;
						tok_b   = mk_tok(K_ONE + {1'b0, one_c.idx}, E_NONE, off_q, line_q,
							col_q, adv_off, adv_line, adv_col);
					end else begin
						eb         = 1'b1;
						tok_b.kind = K_INVALID;
						tok_b.err  = E_UNRECOG;
						halt_d     = 1'b1;
					end
				end else begin
					consume = 1'b1;
				end
			end
		end

		off_d  = consume ? adv_off : off_q;
		line_d = consume ? adv_line : line_q;
		col_d  = consume ? adv_col : col_q;

		// The end marker always returns the lexer to its reset state.
		if (end_marker) begin
			mode_d = M_IDLE;
			dot2_d = 1'b0;
			off_d  = '0;
			line_d = LineOne;
			col_d  = ColOne;
			tso_d  = '0;
			tsl_d  = LineOne;
			tsc_d  = ColOne;
			halt_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pend_q <= 8'h00;
			dot2_q <= 1'b0;
			off_q  <= '0;
			line_q <= LineOne;
			col_q  <= ColOne;
			tso_q  <= '0;
			tsl_q  <= LineOne;
			tsc_q  <= ColOne;
			halt_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			pend_q <= pend_d;
			dot2_q <= dot2_d;
			off_q  <= off_d;
			line_q <= line_d;
			col_q  <= col_d;
			tso_q  <= tso_d;
			tsl_q  <= tsl_d;
			tsc_q  <= tsc_d;
			halt_q <= halt_d;
		end
	end

	// Pack the batch in emission order; ea1 is only ever set with ea0.
	assign push_cnt     = {1'b0, ea0} + {1'b0, ea1} + {1'b0, eb};
	assign push_data[0] = ea0 ? tok_a0 : tok_b;
	assign push_data[1] = ea1 ? tok_a1 : tok_b;
	assign push_data[2] = tok_b;

	ctlt_outq #(
		.DATA_BITS(TokBits)
	) u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_cnt (push_cnt),
		.push_data(push_data),
		.room     (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (head_bits),
		.out_last (last_of_run)
	);

	assign head_tok     = head_bits;
	assign token_kind   = head_tok.kind;
	assign error_code   = head_tok.err;
	assign start_offset = head_tok.so;
	assign start_line   = head_tok.sl;
	assign start_column = head_tok.sc;
	assign end_offset   = head_tok.eo;
	assign end_line     = head_tok.el;
	assign end_column   = head_tok.ec;

endmodule

FILE: verif/tb_c_like_source_tokenizer.sv
// ============================================================================
// tb_c_like_source_tokenizer: self-checking bench for the C-like tokenizer
// Feeds source bytes through the valid/ready input, predicts the tokens each
// byte completes with a behavioral lexer, and compares every token beat field
// by field. A directed table and directed strings cover operators, the end token,
// an unclosed block comment and every error path; random C-like fragments plus noise bytes follow, under several
// idle and stall patterns and one long output hold-off.
// ============================================================================
`timescale 1ns / 1ps

module tb_c_like_source_tokenizer;
	import ctlt_pkg::*;

	localparam int OB = DEF_OFFSET_BITS;
	localparam int LB = DEF_LINE_BITS;
	localparam int CB = DEF_COLUMN_BITS;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		logic [5:0]    kind;
		logic [OB-1:0] so;
		logic [OB-1:0] eo;
		logic [LB-1:0] sl;
		logic [CB-1:0] sc;
		logic [LB-1:0] el;
		logic [CB-1:0] ec;
		logic [2:0]    err;
		logic          last;
	} token_t;

	// One row of the directed table: a byte or the end marker, and for a few
	// rows the kind and error code of the single token it should give.
	typedef struct {
		logic [7:0] b;
		logic       eos;
		logic       typed;
		logic [5:0] kind;
		logic [2:0] err;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] source_byte = 8'h00;
	logic end_marker = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [5:0] token_kind;
	logic [OB-1:0] start_offset, end_offset;
	logic [LB-1:0] start_line, end_line;
	logic [CB-1:0] start_column, end_column;
	logic [2:0] error_code;
	logic last_of_run;

	c_like_source_tokenizer DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.source_byte(source_byte), .end_marker(end_marker),
		.out_valid(out_valid), .out_ready(out_ready),
		.token_kind(token_kind), .start_offset(start_offset), .end_offset(end_offset),
		.start_line(start_line), .start_column(start_column),
		.end_line(end_line), .end_column(end_column),
		.error_code(error_code), .last_of_run(last_of_run)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Predictor state: mirrors the lexer and its cursor.
	mode_t         lx_mode;
	logic [7:0]    lx_pend;
	int            lx_npend;
	logic [OB-1:0] cur_off, tok_off;
	logic [LB-1:0] cur_line, tok_line;
	logic [CB-1:0] cur_col, tok_col;
	logic          lx_halted;

	token_t expected_tokens[$];
	token_t step_tokens[$];
	int     fail_count = 0;
	longint cycle_count = 0;
	int     send_idle_pct = 0;
	int     recv_stall_pct = 0;
	bit     hold_output = 1'b0;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
		$display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, exp);
		fail_count++;
	endtask

	function automatic void lexer_reset();
		lx_mode = M_IDLE;
		lx_pend = 8'h00;
		lx_npend = 0;
		cur_off = '0;
		cur_line = LB'(1);
		cur_col = CB'(1);
		tok_off = '0;
		tok_line = LB'(1);
		tok_col = CB'(1);
		lx_halted = 1'b0;
	endfunction

	function automatic void cursor_step(input logic [7:0] c);
		if (cur_off != '1)
			cur_off++;
		if (c == CH_LF) begin
			cur_col = CB'(1);
			if (cur_line != '1)
				cur_line++;
		end else if (cur_col != '1) begin
			cur_col++;
		end
	endfunction

	function automatic void mark_token();
		tok_off = cur_off;
		tok_line = cur_line;
		tok_col = cur_col;
	endfunction

	function automatic void emit_span(input logic [5:0] k, input logic [2:0] e,
			input logic [OB-1:0] eo, input logic [LB-1:0] el, input logic [CB-1:0] ec);
		token_t t;
		if (step_tokens.size() >= 3)
			return;
		t.kind = k;
		t.so = tok_off;
		t.sl = tok_line;
		t.sc = tok_col;
		t.eo = eo;
		t.el = el;
		t.ec = ec;
		t.err = e;
		t.last = 1'b0;
		step_tokens.insert(step_tokens.size(), t);
	endfunction

	function automatic void emit_at_cursor(input logic [5:0] k, input logic [2:0] e);
		emit_span(k, e, cur_off, cur_line, cur_col);
	endfunction

	function automatic void raise_error(input logic [2:0] e);
		emit_at_cursor(K_INVALID, e);
		lx_halted = 1'b1;
	endfunction

	// Handles one byte, or the end when eos is set. Returns 1 when the same
	// input must be looked at again in the new mode.
	function automatic bit lex_one(input logic [7:0] c, input bit eos);
		op_hit_t h;
		case (lx_mode)
			M_IDLE: begin
				if (eos) begin
					mark_token();
					emit_at_cursor(K_END, E_NONE);
					return 0;
				end
				if (is_blank(c)) begin
					cursor_step(c);
					return 0;
				end
				mark_token();
				if (c == CH_SLASH || c == CH_DOT || two_first(c)) begin
					lx_pend = c;
					lx_npend = 1;
					cursor_step(c);
					lx_mode = M_HOLD;
					return 0;
				end
				if (id_start(c)) begin
					cursor_step(c);
					lx_mode = M_IDENT;
					return 0;
				end
				if (is_digit(c)) begin
					cursor_step(c);
					lx_mode = (c == CH_ZERO) ? M_ZERO : M_DEC;
					return 0;
				end
				if (c == CH_QUOTE) begin
					cursor_step(c);
					lx_mode = M_CHOPEN;
					return 0;
				end
				if (c == CH_DQUOTE) begin
					cursor_step(c);
					lx_mode = M_STR;
					return 0;
				end
				h = one_index(c);
				if (h.hit) begin
					cursor_step(c);
					emit_at_cursor(K_ONE + 6'(h.idx), E_NONE);
					return 0;
				end
				raise_error(E_UNRECOG);
				return 0;
			end
			M_HOLD: begin
				if (lx_pend == CH_SLASH) begin
					if (!eos && (c == CH_SLASH || c == CH_STAR)) begin
						cursor_step(c);
						lx_npend = 0;
						lx_mode = (c == CH_SLASH) ? M_LCOM : M_BCOM;
						return 0;
					end
					emit_at_cursor(K_ONE + 6'(ONE_SLASH), E_NONE);
					lx_mode = M_IDLE;
					lx_npend = 0;
					return 1;
				end
				if (lx_pend == CH_DOT) begin
					if (lx_npend >= 2) begin
						if (!eos && c == CH_DOT) begin
							cursor_step(c);
							emit_at_cursor(K_ELLIPSIS, E_NONE);
							lx_mode = M_IDLE;
							lx_npend = 0;
							return 0;
						end
						// The first of two held dots stands alone; the second
						// becomes the open token.
						begin
							logic [OB-1:0] o1;
							logic [CB-1:0] c1;
							o1 = (tok_off == '1) ? tok_off : tok_off + 1'b1;
							c1 = (tok_col == '1) ? tok_col : tok_col + 1'b1;
							emit_span(K_ONE + 6'(ONE_DOT), E_NONE, o1, tok_line, c1);
							tok_off = o1;
							tok_col = c1;
						end
						lx_npend = 1;
						return 1;
					end
					if (!eos && c == CH_DOT) begin
						lx_npend = 2;
						cursor_step(c);
						return 0;
					end
					emit_at_cursor(K_ONE + 6'(ONE_DOT), E_NONE);
					lx_mode = M_IDLE;
					lx_npend = 0;
					return 1;
				end
				h.hit = 1'b0;
				h.idx = '0;
				if (!eos)
					h = two_index(lx_pend, c);
				if (h.hit) begin
					cursor_step(c);
					emit_at_cursor(K_TWO + 6'(h.idx), E_NONE);
					lx_mode = M_IDLE;
					lx_npend = 0;
					return 0;
				end
				h = one_index(lx_pend);
				if (h.hit)
					emit_at_cursor(K_ONE + 6'(h.idx), E_NONE);
				else
					emit_at_cursor(K_INVALID, E_UNRECOG);
				lx_mode = M_IDLE;
				lx_npend = 0;
				return 1;
			end
			M_LCOM: begin
				if (eos || c == CH_LF) begin
					lx_mode = M_IDLE;
					return 1;
				end
				cursor_step(c);
				return 0;
			end
			M_BCOM, M_BSTAR: begin
				if (eos) begin
					lx_mode = M_IDLE;
					return 1;
				end
				cursor_step(c);
				if (lx_mode == M_BSTAR && c == CH_SLASH)
					lx_mode = M_IDLE;
				else
					lx_mode = (c == CH_STAR) ? M_BSTAR : M_BCOM;
				return 0;
			end
			M_IDENT: begin
				if (!eos && id_cont(c)) begin
					cursor_step(c);
					return 0;
				end
				emit_at_cursor(K_IDENT, E_NONE);
				lx_mode = M_IDLE;
				return 1;
			end
			M_ZERO, M_DEC: begin
				if (!eos && lx_mode == M_ZERO && c == CH_LOWX) begin
					cursor_step(c);
					lx_mode = M_HEX0;
					return 0;
				end
				if (!eos && is_digit(c)) begin
					cursor_step(c);
					lx_mode = M_DEC;
					return 0;
				end
				if (!eos && c == CH_DOT) begin
					cursor_step(c);
					lx_mode = M_FLOAT;
					return 0;
				end
				emit_at_cursor(K_INT, E_NONE);
				lx_mode = M_IDLE;
				return 1;
			end
			M_HEX0: begin
				if (!eos && is_hex(c)) begin
					cursor_step(c);
					lx_mode = M_HEX;
					return 0;
				end
				raise_error(E_HEX_EMPTY);
				return 0;
			end
			M_HEX: begin
				if (!eos && is_hex(c)) begin
					cursor_step(c);
					return 0;
				end
				emit_at_cursor(K_INT, E_NONE);
				lx_mode = M_IDLE;
				return 1;
			end
			M_FLOAT: begin
				if (!eos && is_digit(c)) begin
					cursor_step(c);
					return 0;
				end
				emit_at_cursor(K_FLOAT, E_NONE);
				lx_mode = M_IDLE;
				return 1;
			end
			M_CHOPEN: begin
				if (eos) begin
					raise_error(E_CHAR_OPEN);
					return 0;
				end
				if (c == CH_BSLASH) begin
					cursor_step(c);
					lx_mode = M_CHESC;
					return 0;
				end
				if (c == CH_QUOTE) begin
					raise_error(E_CHAR_NONE);
					return 0;
				end
				cursor_step(c);
				lx_mode = M_CHBODY;
				return 0;
			end
			M_CHESC: begin
				if (eos) begin
					raise_error(E_CHAR_OPEN);
					return 0;
				end
				cursor_step(c);
				lx_mode = M_CHBODY;
				return 0;
			end
			M_CHBODY: begin
				if (!eos && c == CH_QUOTE) begin
					cursor_step(c);
					emit_at_cursor(K_CHAR, E_NONE);
					lx_mode = M_IDLE;
					return 0;
				end
				raise_error(E_CHAR_LONG);
				return 0;
			end
			M_STR, M_STRESC: begin
				if (eos) begin
					raise_error(E_STR_OPEN);
					return 0;
				end
				cursor_step(c);
				if (lx_mode == M_STRESC)
					lx_mode = M_STR;
				else if (c == CH_DQUOTE) begin
					emit_at_cursor(K_STRING, E_NONE);
					lx_mode = M_IDLE;
				end else if (c == CH_BSLASH)
					lx_mode = M_STRESC;
				return 0;
			end
			default: begin
				lx_mode = M_IDLE;
				return 1;
			end
		endcase
	endfunction

	// Predicts the tokens for one accepted beat into step_tokens.
	function automatic void predict_tokens(input logic [7:0] c, input logic eos);
		step_tokens.delete();
		if (lx_halted) begin
			if (eos)
				lexer_reset();
			return;
		end
		for (int n = 0; n < 6; n++)
			if (!lex_one(c, eos))
				break;
		if (eos)
			lexer_reset();
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].last = 1'b1;
	endfunction

	// Offers one beat and waits until it is accepted; the prediction is made
	// at the accepting edge. Valid stays up for a following beat and is only
	// dropped by an idle gap or at the end of the run.
	task automatic send_beat(input logic [7:0] c, input logic eos, input bit typed,
			input logic [5:0] k, input logic [2:0] e);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		source_byte <= c;
		end_marker <= eos;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_tokens(c, eos);
		if (typed) begin
			if (step_tokens.size() != 1)
				report("typed row token count", step_tokens.size(), 1);
			else begin
				if (step_tokens[0].kind != k)
					report("typed row kind", step_tokens[0].kind, k);
				if (step_tokens[0].err != e)
					report("typed row error", step_tokens[0].err, e);
			end
		end
		foreach (step_tokens[i])
			expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(s[i], 1'b0, 0, '0, '0);
	endtask

	task automatic send_end();
		send_beat(8'h00, 1'b1, 0, '0, '0);
	endtask

	// Output side: stall at random or during a hold-off, and check each beat.
	initial begin
		token_t t;
		forever begin
			@(negedge clk);
			out_ready <= !hold_output && ($urandom_range(99) >= recv_stall_pct);
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (expected_tokens.size() == 0) begin
					report("token beat with nothing expected, kind", token_kind, 0);
				end else begin
					t = expected_tokens.pop_front();
					if (token_kind !== t.kind) report("token_kind", token_kind, t.kind);
					if (start_offset !== t.so) report("start_offset", start_offset, t.so);
					if (end_offset !== t.eo) report("end_offset", end_offset, t.eo);
					if (start_line !== t.sl) report("start_line", start_line, t.sl);
					if (start_column !== t.sc) report("start_column", start_column, t.sc);
					if (end_line !== t.el) report("end_line", end_line, t.el);
					if (end_column !== t.ec) report("end_column", end_column, t.ec);
					if (error_code !== t.err) report("error_code", error_code, t.err);
					if (last_of_run !== t.last) report("last_of_run", last_of_run, t.last);
				end
			end
		end
	end

	// Watchdog on the total run length.
	initial begin
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Directed rows, exactly one token per row where a result is typed in.
	stim_row_t dir_rows[$];

	function automatic void add_row(input logic [7:0] b, input logic eos, input bit typed,
			input logic [5:0] k, input logic [2:0] e);
		stim_row_t r;
		r.b = b;
		r.eos = eos;
		r.typed = typed;
		r.kind = k;
		r.err = e;
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	// Random C-like fragment: mostly well formed, sometimes broken.
	function automatic string random_fragment();
		string s;
		int n;
		case ($urandom_range(13))
			0: begin
				s = "_";
				n = $urandom_range(4);
				for (int i = 0; i < n; i++)
					s = {s, string'(8'($urandom_range(25) + 8'h61))};
			end
			1: s = $sformatf("%0d", $urandom_range(99999));
			2: s = $sformatf("0x%0h", $urandom_range(65535));
			3: s = $sformatf("%0d.%0d", $urandom_range(99), $urandom_range(99));
			4: s = {"'", string'(8'($urandom_range(94) + 8'h20)), "'"};
			5: s = "'\\n'";
			6: s = "\"a\\\"b c\"";
			7: s = "...";
			8: begin
				string ops[13] = '{"->", "&&", "||", "==", "!=", "<=", ">=",
					"++", "--", "<<", ">>", "+=", "-="};
				s = ops[$urandom_range(12)];
			end
			9: begin
				string one_ops = "(){}[]<>:,.;+-*/=!~&|?%^";
				int k = $urandom_range(23);
				s = one_ops.substr(k, k);
			end
			10: s = ($urandom_range(1) != 0) ? "/* x * y */" : "// note\n";
			11: s = ($urandom_range(1) != 0) ? "\n" : " \t\r";
			12: s = "..";
			default: s = string'(8'($urandom_range(255)));
		endcase
		return s;
	endfunction

	initial begin
		int total;
		string chunk;
		lexer_reset();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, no idling.
		add_row(8'h00, 1'b1, 1, K_END, E_NONE);          // end token on empty source
		add_row(8'h28, 1'b0, 1, K_ONE, E_NONE);          // '(' first one-char operator
		add_row(8'h5E, 1'b0, 1, K_ONE + 6'd23, E_NONE);  // '^' last one-char operator
		add_row(8'h2D, 1'b0, 0, '0, '0);                 // '-' then '>' gives arrow
		add_row(8'h3E, 1'b0, 1, K_TWO, E_NONE);
		add_row(8'h2E, 1'b0, 0, '0, '0);                 // two dots then '(' gives three
		add_row(8'h2E, 1'b0, 0, '0, '0);
		add_row(8'h28, 1'b0, 0, '0, '0);
		add_row(8'h2F, 1'b0, 0, '0, '0);                 // lone slash flushed at the end
		add_row(8'h00, 1'b1, 0, '0, '0);
		add_row(8'h27, 1'b0, 0, '0, '0);                 // empty char literal
		add_row(8'h27, 1'b0, 1, K_INVALID, E_CHAR_NONE);
		add_row(8'h41, 1'b0, 0, '0, '0);                 // ignored after the error
		add_row(8'h00, 1'b1, 0, '0, '0);
		add_row(8'h40, 1'b0, 1, K_INVALID, E_UNRECOG);   // unrecognized byte
		add_row(8'h00, 1'b1, 0, '0, '0);
		add_row(8'hFF, 1'b0, 1, K_INVALID, E_UNRECOG);   // top byte value
		add_row(8'h00, 1'b1, 0, '0, '0);
		add_row(8'h22, 1'b0, 0, '0, '0);                 // unterminated string at end
		add_row(8'h00, 1'b1, 1, K_INVALID, E_STR_OPEN);
		add_row(8'h27, 1'b0, 0, '0, '0);                 // unterminated char at end
		add_row(8'h00, 1'b1, 1, K_INVALID, E_CHAR_OPEN);
		foreach (dir_rows[i])
			send_beat(dir_rows[i].b, dir_rows[i].eos, dir_rows[i].typed,
				dir_rows[i].kind, dir_rows[i].err);
		send_text("0x;");  // hex without digits
		send_end();
		send_text("'ab'"); // char too long
		send_end();
		send_text("/* open *");
		send_end();

		// Random part in phases of idling and stalling.
		total = 0;
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
				3: begin send_idle_pct = 12; recv_stall_pct = 12; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			// In the last phase the output is held off for a long stretch
			// while bytes keep coming, so the token buffer fills up.
			if (ph == 4)
				fork
					begin
						hold_output = 1'b1;
						repeat (300) @(negedge clk);
						hold_output = 1'b0;
					end
				join_none
			while (total < 64 * (ph + 1)) begin
				chunk = random_fragment();
				send_text(chunk);
				total += chunk.len();
				if ($urandom_range(9) == 0) begin
					send_text(" ");
					total++;
				end
				if ($urandom_range(29) == 0)
					send_end();
			end
			send_end();
		end
		in_valid <= 1'b0;

		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
